// ===== rtl/uwbf_pkg.sv =====
// Shared types and constants of the position frame filter.
`timescale 1ns / 1ps

package uwbf_pkg;

	// Frame header bytes.
	localparam logic [7:0] HDR0 = 8'h57;
	localparam logic [7:0] HDR1 = 8'h58;

	// Payload byte positions of the fix, low byte first.
	localparam int X_LO_POS = 6;
	localparam int X_HI_POS = 7;
	localparam int Y_LO_POS = 8;
	localparam int Y_HI_POS = 9;

	// Coordinate width and register reset values.
	localparam int COORD_W = 16;
	localparam logic [COORD_W-1:0] REJECT_DIST_RESET = 16'd100;
	localparam logic [COORD_W-1:0] START_RESET = 16'd0;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_REJECT_DIST = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_X = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 2'd2;

	// Result status codes.
	typedef enum logic [1:0] {
		STATUS_AVG = 2'd0,
		STATUS_FILL = 2'd1,
		STATUS_REJECT = 2'd2
	} status_t;

	// One decoded position fix.
	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} fix_t;

	// One configuration write.
	typedef struct packed {
		logic valid;
		logic [CFG_IDX_W-1:0] index;
		logic [COORD_W-1:0] data;
	} cfg_wr_t;

	// One finished result.
	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		status_t status;
	} result_t;

endpackage

// ===== rtl/uwbf_parser.sv =====
// Frame parser: header hunt, payload count and fix extraction.
`timescale 1ns / 1ps

module uwbf_parser #(
	parameter int PAYLOAD_LEN = 16
) (
	input logic clk,
	input logic arst_n,
	input logic take,
	input logic [7:0] rx_byte,
	output logic fix_valid,
	output uwbf_pkg::fix_t fix
);
	import uwbf_pkg::*;

	localparam int IDX_W = $clog2(PAYLOAD_LEN);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_LEN - 1);
	localparam logic [IDX_W-1:0] X_LO_IDX = IDX_W'(X_LO_POS);
	localparam logic [IDX_W-1:0] X_HI_IDX = IDX_W'(X_HI_POS);
	localparam logic [IDX_W-1:0] Y_LO_IDX = IDX_W'(Y_LO_POS);
	localparam logic [IDX_W-1:0] Y_HI_IDX = IDX_W'(Y_HI_POS);

	logic in_payload_q;
	logic prev_hdr0_q;
	logic [IDX_W-1:0] idx_q;
	logic [7:0] low_q;
	logic [COORD_W-1:0] frame_x_q;
	logic [COORD_W-1:0] frame_y_q;
	logic [COORD_W-1:0] hi_word;
	logic last_byte;

	// The high byte completes a coordinate in the same cycle it arrives.
	always_comb begin
		hi_word = {rx_byte, low_q};
		last_byte = in_payload_q && (idx_q == LAST_IDX);
		fix_valid = take && last_byte;
		fix.x = (in_payload_q && idx_q == X_HI_IDX) ? hi_word : frame_x_q;
		fix.y = (in_payload_q && idx_q == Y_HI_IDX) ? hi_word : frame_y_q;
	end

	// Header hunt and payload position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q <= 1'b0;
			prev_hdr0_q <= 1'b0;
			idx_q <= '0;
		end else if (take) begin
			if (!in_payload_q) begin
				if (prev_hdr0_q && rx_byte == HDR1) begin
					in_payload_q <= 1'b1;
					idx_q <= '0;
					prev_hdr0_q <= 1'b0;
				end else begin
					prev_hdr0_q <= (rx_byte == HDR0);
				end
			end else if (last_byte) begin
				in_payload_q <= 1'b0;
				idx_q <= '0;
				prev_hdr0_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// Coordinate bytes of the payload.
	always_ff @(posedge clk) begin
		if (take && in_payload_q) begin
			if (idx_q == X_LO_IDX || idx_q == Y_LO_IDX) begin
				low_q <= rx_byte;
			end
			if (idx_q == X_HI_IDX) begin
				frame_x_q <= hi_word;
			end
			if (idx_q == Y_HI_IDX) begin
				frame_y_q <= hi_word;
			end
		end
	end

endmodule

// ===== rtl/uwbf_cell.sv =====
// One window cell: holds one accepted fix and passes it on when the window shifts.
`timescale 1ns / 1ps

module uwbf_cell (
	input logic clk,
	input logic shift,
	input uwbf_pkg::fix_t d,
	output uwbf_pkg::fix_t q
);
	import uwbf_pkg::*;

	fix_t fix_q;

	// Take the neighbor's fix on every window shift.
	always_ff @(posedge clk) begin
		if (shift) begin
			fix_q <= d;
		end
	end

	assign q = fix_q;

endmodule

// ===== rtl/uwbf_window.sv =====
// Outlier test, chain of window cells, running sums and mean stage.
`timescale 1ns / 1ps

module uwbf_window #(
	parameter int WINDOW = 5
) (
	input logic clk,
	input logic arst_n,
	input uwbf_pkg::cfg_wr_t cfg,
	input logic fix_valid,
	input uwbf_pkg::fix_t fix,
	input logic res_take,
	output logic res_valid,
	output uwbf_pkg::result_t res
);
	import uwbf_pkg::*;

	// The cells keep the previous WINDOW-1 fixes; the new fix completes the window.
	localparam int CELLS = WINDOW - 1;
	localparam int LOG_W = $clog2(WINDOW);
	localparam int CNT_W = LOG_W;
	localparam int SUM_W = COORD_W + LOG_W;
	// Reciprocal multiply, exact for every sum below 2**SUM_W.
	localparam int MUL_SHIFT = SUM_W + LOG_W;
	localparam int MUL_W = SUM_W + 1;
	localparam longint unsigned MUL_FULL =
		((64'd1 << MUL_SHIFT) + longint'(WINDOW) - 64'd1) / longint'(WINDOW);
	localparam logic [MUL_W-1:0] MUL_C = MUL_W'(MUL_FULL);
	localparam int PROD_W = SUM_W + MUL_W;

	logic [COORD_W-1:0] reject_dist_q;
	logic [COORD_W-1:0] ref_x_q;
	logic [COORD_W-1:0] ref_y_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] sum_x_q;
	logic [SUM_W-1:0] sum_y_q;

	logic valid_s1;
	logic [SUM_W-1:0] total_x_s1;
	logic [SUM_W-1:0] total_y_s1;
	status_t status_s1;

	fix_t chain [CELLS+1];
	fix_t oldest;
	logic full;
	logic [COORD_W-1:0] dev_x;
	logic [COORD_W-1:0] dev_y;
	logic reject;
	logic accept;
	logic [SUM_W-1:0] total_x;
	logic [SUM_W-1:0] total_y;
	status_t status;
	logic [PROD_W-1:0] prod_x;
	logic [PROD_W-1:0] prod_y;
	logic [COORD_W-1:0] mean_x;
	logic [COORD_W-1:0] mean_y;

	// Row of cells: the new fix enters the first cell, the oldest sits in the last.
	assign chain[0] = fix;
	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		uwbf_cell u_cell (
			.clk   (clk),
			.shift (accept),
			.d     (chain[i]),
			.q     (chain[i+1])
		);
	end
	assign oldest = chain[CELLS];

	// Per-axis deviation from the reference and the verdict on the fix.
	always_comb begin
		full = (cnt_q == CNT_W'(CELLS));
		dev_x = (fix.x >= ref_x_q) ? (fix.x - ref_x_q) : (ref_x_q - fix.x);
		dev_y = (fix.y >= ref_y_q) ? (fix.y - ref_y_q) : (ref_y_q - fix.y);
		reject = (dev_x > reject_dist_q) || (dev_y > reject_dist_q);
		accept = fix_valid && !reject;
		total_x = sum_x_q + SUM_W'(fix.x);
		total_y = sum_y_q + SUM_W'(fix.y);
		if (reject) begin
			status = STATUS_REJECT;
		end else if (full) begin
			status = STATUS_AVG;
		end else begin
			status = STATUS_FILL;
		end
	end

	// Control state: registers, reference, fill count and running sums.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reject_dist_q <= REJECT_DIST_RESET;
			ref_x_q <= START_RESET;
			ref_y_q <= START_RESET;
			cnt_q <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					CFG_REJECT_DIST: reject_dist_q <= cfg.data;
					CFG_START_X: ref_x_q <= cfg.data;
					CFG_START_Y: ref_y_q <= cfg.data;
					default: ;
				endcase
			end
			if (res_take && status_s1 == STATUS_AVG) begin
				ref_x_q <= mean_x;
				ref_y_q <= mean_y;
			end
			if (accept) begin
				if (full) begin
					sum_x_q <= total_x - SUM_W'(oldest.x);
					sum_y_q <= total_y - SUM_W'(oldest.y);
				end else begin
					sum_x_q <= total_x;
					sum_y_q <= total_y;
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (fix_valid) begin
				valid_s1 <= 1'b1;
			end else if (res_take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Window total and status of the frame wait here for the mean.
	always_ff @(posedge clk) begin
		if (fix_valid) begin
			total_x_s1 <= total_x;
			total_y_s1 <= total_y;
			status_s1 <= status;
		end
	end

	// Mean by reciprocal multiply; the top level registers the result.
	always_comb begin
		prod_x = PROD_W'(total_x_s1) * PROD_W'(MUL_C);
		prod_y = PROD_W'(total_y_s1) * PROD_W'(MUL_C);
		mean_x = prod_x[MUL_SHIFT +: COORD_W];
		mean_y = prod_y[MUL_SHIFT +: COORD_W];
		res_valid = valid_s1;
		res.status = status_s1;
		res.x = (status_s1 == STATUS_AVG) ? mean_x : '0;
		res.y = (status_s1 == STATUS_AVG) ? mean_y : '0;
	end

`ifndef SYNTHESIS
	// The fill count never passes the number of cells.
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CNT_W'(CELLS))
		else $error("window fill count out of range");

	// An empty window has empty running sums.
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> sum_x_q == '0 && sum_y_q == '0)
		else $error("running sum not empty with empty window");

	// A rejected fix leaves the window untouched.
	assert property (@(posedge clk) disable iff (!arst_n)
		fix_valid && reject |=> $stable(cnt_q) && $stable(sum_x_q) && $stable(sum_y_q))
		else $error("rejected fix changed the window");

	// A waiting frame total holds until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !res_take |=> valid_s1 && $stable(total_x_s1) && $stable(status_s1))
		else $error("waiting frame result lost");
`endif

endmodule

// ===== rtl/uwb_position_frame_filter.sv =====
// Top level of the position frame filter: parser, window and output register.
`timescale 1ns / 1ps

// Takes one received byte per clock cycle, finds frames that open with 0x57 0x58,
// reads the x and y fix from a PAYLOAD_LEN-byte payload and gives one result per
// frame: a rejected outlier, an accepted fix while the window fills, or the
// truncated mean of the last WINDOW accepted fixes, which then becomes the new
// reference. The result passes the window register, then the output register; the
// mean comes from a running sum kept beside the row of window cells and one
// reciprocal multiply. Input bytes are stalled only while a finished result waits
// behind a held output register. Writing start_x or start_y loads the reference at
// once. The user must write configuration while the block is idle (not enforced).
module uwb_position_frame_filter #(
	parameter int WINDOW = 5,
	parameter int PAYLOAD_LEN = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] rx_byte,
	output logic out_valid,
	input logic out_stall,
	output logic [15:0] pos_x,
	output logic [15:0] pos_y,
	output logic [1:0] frame_status,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data
);
	import uwbf_pkg::*;

	cfg_wr_t cfg_w;
	logic take;
	logic fix_valid;
	fix_t fix;
	logic res_valid;
	logic res_take;
	result_t res;

	logic out_valid_q;
	result_t out_q;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;
	assign cfg_w.valid = cfg_valid && cfg_ready;
	assign cfg_w.index = cfg_index;
	assign cfg_w.data = cfg_data;

	// A waiting result moves on when the output register is free or being read.
	assign res_take = res_valid && (!out_valid_q || !out_stall);
	assign in_stall = res_valid && !res_take;
	assign take = in_valid && !in_stall;

	uwbf_parser #(
		.PAYLOAD_LEN (PAYLOAD_LEN)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.rx_byte   (rx_byte),
		.fix_valid (fix_valid),
		.fix       (fix)
	);

	uwbf_window #(
		.WINDOW (WINDOW)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_w),
		.fix_valid (fix_valid),
		.fix       (fix),
		.res_take  (res_take),
		.res_valid (res_valid),
		.res       (res)
	);

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x = out_q.x;
	assign pos_y = out_q.y;
	assign frame_status = out_q.status;

`ifndef SYNTHESIS
	// Input is held back only behind a full, held output.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with free output");

	// Only an averaged result carries a position.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_q.status != STATUS_AVG |-> pos_x == '0 && pos_y == '0)
		else $error("position on a non-averaged result");

	// A read output with nothing behind it empties.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !res_valid |=> !out_valid)
		else $error("result repeated on output");
`endif

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the position frame filter: frame parsing, outlier rejection, window mean.
`timescale 1ns / 1ps

module tb;
	import uwbf_pkg::*;

	localparam int WIN = 5;
	localparam int FRAME_LEN = 16;
	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam int LAT_CYCLES = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int HOLD_PHASE = 4;
	localparam int NUM_PHASES = 6;
	localparam int RAND_BYTES = 1040;
	localparam int RAND_RESULTS = 48;
	localparam int FILL_RANDOM = -1;
	localparam int SCRIPT_LEN = 22;

	typedef enum logic [1:0] {ROW_FRAME, ROW_REL, ROW_CFG} row_kind_t;
	typedef enum logic [1:0] {LEAD_PLAIN, LEAD_REPEAT, LEAD_NOISE, LEAD_RANDOM} lead_t;

	// One scripted step: a frame (absolute or relative to the reference) or a register write.
	typedef struct packed {
		row_kind_t kind;
		lead_t lead;
		logic [7:0] fill;
		logic [15:0] a;
		logic [15:0] b;
		logic pinned;
		status_t st;
		logic [15:0] ex;
		logic [15:0] ey;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] rx_byte = 8'h00;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [15:0] pos_x;
	logic [15:0] pos_y;
	logic [1:0] frame_status;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = 2'd0;
	logic [15:0] cfg_data = 16'h0000;

	// Filter state as predicted by the testbench.
	logic in_frame;
	logic saw_sync0;
	int byte_pos;
	logic [7:0] lo_hold;
	logic [15:0] fix_x, fix_y;
	logic [15:0] win_x [WIN];
	logic [15:0] win_y [WIN];
	int win_fill;
	logic [15:0] anchor_x, anchor_y;
	logic [15:0] max_dev;

	result_t pending_fixes [$];
	result_t pin_res;
	bit pin_valid = 1'b0;
	int err_count = 0;
	int frames_done = 0;
	int frame_bytes = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	bit long_hold = 1'b0;
	int hold_cnt = 0;

	// Early frames check reset behavior, then the extremes of distance and coordinates.
	row_t frame_script [SCRIPT_LEN] = '{
		'{ROW_FRAME, LEAD_PLAIN, 8'h00, 16'd0, 16'd0, 1'b1, STATUS_FILL, 16'd0, 16'd0},
		'{ROW_FRAME, LEAD_PLAIN, 8'hFF, 16'd101, 16'd0, 1'b1, STATUS_REJECT, 16'd0, 16'd0},
		'{ROW_FRAME, LEAD_PLAIN, 8'h57, 16'd100, 16'd100, 1'b1, STATUS_FILL, 16'd0, 16'd0},
		'{ROW_FRAME, LEAD_REPEAT, 8'h58, 16'd0, 16'd101, 1'b1, STATUS_REJECT, 16'd0, 16'd0},
		'{ROW_FRAME, LEAD_NOISE, 8'h57, 16'd50, 16'd50, 1'b1, STATUS_FILL, 16'd0, 16'd0},
		'{ROW_FRAME, LEAD_PLAIN, 8'h58, 16'd7, 16'd3, 1'b1, STATUS_FILL, 16'd0, 16'd0},
		'{ROW_FRAME, LEAD_PLAIN, 8'h00, 16'd1, 16'd2, 1'b0, STATUS_AVG, 16'd0, 16'd0},
		'{ROW_FRAME, LEAD_PLAIN, 8'hAA, 16'd20, 16'd40, 1'b0, STATUS_AVG, 16'd0, 16'd0},
		'{ROW_CFG, LEAD_PLAIN, 8'h00, 16'(CFG_REJECT_DIST), 16'hFFFF, 1'b0, STATUS_AVG,
			16'd0, 16'd0},
		'{ROW_CFG, LEAD_PLAIN, 8'h00, 16'(CFG_START_X), 16'hFFFF, 1'b0, STATUS_AVG, 16'd0, 16'd0},
		'{ROW_CFG, LEAD_PLAIN, 8'h00, 16'(CFG_START_Y), 16'hFFFF, 1'b0, STATUS_AVG, 16'd0, 16'd0},
		'{ROW_FRAME, LEAD_PLAIN, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, STATUS_AVG, 16'd0, 16'd0},
		'{ROW_FRAME, LEAD_PLAIN, 8'h00, 16'h0000, 16'hFFFF, 1'b0, STATUS_AVG, 16'd0, 16'd0},
		'{ROW_CFG, LEAD_PLAIN, 8'h00, 16'(CFG_UNUSED), 16'h0000, 1'b0, STATUS_AVG, 16'd0, 16'd0},
		'{ROW_CFG, LEAD_PLAIN, 8'h00, 16'(CFG_REJECT_DIST), 16'h0000, 1'b0, STATUS_AVG,
			16'd0, 16'd0},
		'{ROW_REL, LEAD_PLAIN, 8'h00, 16'h0000, 16'h0000, 1'b0, STATUS_AVG, 16'd0, 16'd0},
		'{ROW_REL, LEAD_PLAIN, 8'h00, 16'h0001, 16'h0000, 1'b1, STATUS_REJECT, 16'd0, 16'd0},
		'{ROW_REL, LEAD_NOISE, 8'h57, 16'h0000, 16'hFFFF, 1'b1, STATUS_REJECT, 16'd0, 16'd0},
		'{ROW_CFG, LEAD_PLAIN, 8'h00, 16'(CFG_START_X), 16'h0000, 1'b0, STATUS_AVG, 16'd0, 16'd0},
		'{ROW_CFG, LEAD_PLAIN, 8'h00, 16'(CFG_START_Y), 16'h0000, 1'b0, STATUS_AVG, 16'd0, 16'd0},
		'{ROW_CFG, LEAD_PLAIN, 8'h00, 16'(CFG_REJECT_DIST), 16'd100, 1'b0, STATUS_AVG,
			16'd0, 16'd0},
		'{ROW_FRAME, LEAD_REPEAT, 8'h00, 16'd100, 16'd0, 1'b0, STATUS_AVG, 16'd0, 16'd0}
	};

	uwb_position_frame_filter #(
		.WINDOW(WIN),
		.PAYLOAD_LEN(FRAME_LEN)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.frame_status(frame_status),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Clock with a 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Brings the predicted filter state to its reset values.
	task automatic filter_reset();
		in_frame = 1'b0;
		saw_sync0 = 1'b0;
		byte_pos = 0;
		lo_hold = 8'h00;
		fix_x = 16'h0000;
		fix_y = 16'h0000;
		for (int k = 0; k < WIN; k++) begin
			win_x[k] = 16'h0000;
			win_y[k] = 16'h0000;
		end
		win_fill = 0;
		max_dev = REJECT_DIST_RESET;
		anchor_x = START_RESET;
		anchor_y = START_RESET;
	endtask

	// A register write; a new start point also moves the reference at once.
	task automatic filter_config(input logic [1:0] idx, input logic [15:0] val);
		case (idx)
			CFG_REJECT_DIST: max_dev = val;
			CFG_START_X: anchor_x = val;
			CFG_START_Y: anchor_y = val;
			default: ;
		endcase
	endtask

	// True when a coordinate lies farther than the reject distance from the reference.
	function automatic bit off_limits(input logic [15:0] v, input logic [15:0] r);
		int d;
		d = (v >= r) ? int'(v) - int'(r) : int'(r) - int'(v);
		return d > int'(max_dev);
	endfunction

	// Takes one byte; returns 1 with the finished result on the last payload byte.
	function automatic bit filter_byte(input logic [7:0] b, output result_t r);
		int unsigned sx, sy;
		r = '0;
		if (!in_frame) begin
			if (saw_sync0 && b == HDR1) begin
				in_frame = 1'b1;
				byte_pos = 0;
				saw_sync0 = 1'b0;
			end else begin
				saw_sync0 = (b == HDR0);
			end
			return 1'b0;
		end
		case (byte_pos)
			X_LO_POS, Y_LO_POS: lo_hold = b;
			X_HI_POS: fix_x = {b, lo_hold};
			Y_HI_POS: fix_y = {b, lo_hold};
			default: ;
		endcase
		if (byte_pos + 1 < FRAME_LEN) begin
			byte_pos++;
			return 1'b0;
		end
		in_frame = 1'b0;
		byte_pos = 0;
		saw_sync0 = 1'b0;
		if (off_limits(fix_x, anchor_x) || off_limits(fix_y, anchor_y)) begin
			r.status = STATUS_REJECT;
			return 1'b1;
		end
		win_x[win_fill] = fix_x;
		win_y[win_fill] = fix_y;
		win_fill++;
		if (win_fill < WIN) begin
			r.status = STATUS_FILL;
			return 1'b1;
		end
		// Full window: the truncated mean becomes the reference and the oldest fix leaves.
		sx = 0;
		sy = 0;
		for (int k = 0; k < WIN; k++) begin
			sx += win_x[k];
			sy += win_y[k];
		end
		anchor_x = 16'(sx / WIN);
		anchor_y = 16'(sy / WIN);
		for (int k = 0; k + 1 < WIN; k++) begin
			win_x[k] = win_x[k + 1];
			win_y[k] = win_y[k + 1];
		end
		win_fill = WIN - 1;
		r.x = anchor_x;
		r.y = anchor_y;
		r.status = STATUS_AVG;
		return 1'b1;
	endfunction

	// A coordinate within the reject distance of c, with the span capped to keep hits likely.
	function automatic logic [15:0] near_coord(input logic [15:0] c);
		int span, v;
		span = (max_dev > 16'd2000) ? 2000 : int'(max_dev);
		v = int'(c) + int'($urandom_range(0, 2 * span)) - span;
		return v[15:0];
	endfunction

	// Receiver: random stalls, or one long hold counted here while long_hold is set.
	always @(negedge clk) begin
		if (long_hold && hold_cnt < HOLD_CYCLES) begin
			out_stall <= 1'b1;
			hold_cnt <= hold_cnt + 1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
			if (!long_hold)
				hold_cnt <= 0;
		end
	end

	// Checks each taken result, then predicts from each taken byte.
	always @(posedge clk) begin
		result_t got, want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_fixes.size() == 0) begin
					$error("unexpected result x=%0d y=%0d status=%0d", pos_x, pos_y, frame_status);
					err_count++;
				end else begin
					want = pending_fixes.pop_front();
					if (pos_x !== want.x) begin
						$error("pos_x: expected %0d, got %0d", want.x, pos_x);
						err_count++;
					end
					if (pos_y !== want.y) begin
						$error("pos_y: expected %0d, got %0d", want.y, pos_y);
						err_count++;
					end
					if (frame_status !== want.status) begin
						$error("frame_status: expected %0d, got %0d", want.status, frame_status);
						err_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (filter_byte(rx_byte, got)) begin
					if (pin_valid) begin
						pending_fixes.push_back(pin_res);
						pin_valid = 1'b0;
					end else begin
						pending_fixes.push_back(got);
					end
					frames_done++;
				end
			end
		end
	end

	// Offers one item after a random gap; returns at the falling edge after it is taken.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Lead-in bytes, header and payload with the fix at its fixed positions.
	task automatic send_frame(input lead_t lead, input int fill, input logic [15:0] x,
			input logic [15:0] y);
		int i, n;
		logic [7:0] b;
		case (lead)
			LEAD_REPEAT: begin
				send_byte(HDR0);
				send_byte(HDR0);
			end
			LEAD_NOISE: begin
				send_byte(HDR1);
				send_byte(HDR0);
				send_byte(8'h00);
			end
			LEAD_RANDOM: begin
				n = $urandom_range(1, 4);
				for (i = 0; i < n; i++)
					send_byte(8'($urandom_range(0, 255)));
			end
			default: ;
		endcase
		send_byte(HDR0);
		send_byte(HDR1);
		for (i = 0; i < FRAME_LEN; i++) begin
			case (i)
				X_LO_POS: b = x[7:0];
				X_HI_POS: b = x[15:8];
				Y_LO_POS: b = y[7:0];
				Y_HI_POS: b = y[15:8];
				default: b = (fill == FILL_RANDOM) ? 8'($urandom_range(0, 255)) : fill[7:0];
			endcase
			send_byte(b);
		end
		frame_bytes += 2 + FRAME_LEN;
	endtask

	// Stops sending and waits until every result is in and the pipeline has emptied.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_fixes.size() != 0)
			@(posedge clk);
		repeat (LAT_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// One register write, entered and left at a falling edge.
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		filter_config(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Stimulus: scripted frames, then random phases with different idling and settings.
	initial begin
		row_t row;
		logic [15:0] fx, fy, rej_dist, sx, sy;
		int p, roll, d, v, fill, rand_start, rand_done;
		lead_t lead;

		filter_reset();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < SCRIPT_LEN; i++) begin
			row = frame_script[i];
			if (row.kind == ROW_CFG) begin
				settle();
				write_reg(row.a[1:0], row.b);
			end else begin
				if (row.kind == ROW_REL) begin
					fx = anchor_x + row.a;
					fy = anchor_y + row.b;
				end else begin
					fx = row.a;
					fy = row.b;
				end
				if (row.pinned) begin
					pin_res.x = row.ex;
					pin_res.y = row.ey;
					pin_res.status = row.st;
					pin_valid = 1'b1;
				end
				send_frame(row.lead, int'(row.fill), fx, fy);
			end
		end

		rand_start = frame_bytes;
		rand_done = frames_done;
		for (p = 0; p < NUM_PHASES; p++) begin
			settle();
			case (p)
				1: begin send_idle_pct = 72; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 72; end
				3: begin send_idle_pct = 34; stall_pct = 34; end
				5: begin send_idle_pct = 34; stall_pct = 0; end
				default: begin send_idle_pct = 0; stall_pct = 0; end
			endcase

			// New settings for this phase, extremes included.
			roll = (p == 0) ? 3 : $urandom_range(0, 3);
			case (roll)
				0: rej_dist = 16'h0000;
				1: rej_dist = 16'hFFFF;
				2: rej_dist = 16'($urandom_range(0, 65535));
				default: rej_dist = 16'($urandom_range(1, 500));
			endcase
			if ($urandom_range(0, 3) == 0)
				sx = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			else
				sx = 16'($urandom_range(0, 65535));
			if ($urandom_range(0, 3) == 0)
				sy = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			else
				sy = 16'($urandom_range(0, 65535));
			write_reg(CFG_START_X, sx);
			write_reg(CFG_START_Y, sy);
			write_reg(CFG_REJECT_DIST, rej_dist);
			write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));

			if (p == HOLD_PHASE)
				long_hold = 1'b1;
			while (frame_bytes - rand_start < RAND_BYTES * (p + 1) / NUM_PHASES ||
					(p == NUM_PHASES - 1 && frames_done - rand_done < RAND_RESULTS)) begin
				roll = $urandom_range(0, 99);
				if (roll < 60)
					lead = LEAD_PLAIN;
				else if (roll < 70)
					lead = LEAD_REPEAT;
				else if (roll < 80)
					lead = LEAD_NOISE;
				else
					lead = LEAD_RANDOM;
				fill = ($urandom_range(0, 9) == 0) ? int'(HDR0) : FILL_RANDOM;

				// Mostly fixes near the reference, some anywhere, some right on the boundary.
				fx = near_coord(anchor_x);
				fy = near_coord(anchor_y);
				roll = $urandom_range(0, 99);
				if (roll >= 85) begin
					case ($urandom_range(0, 3))
						0: d = int'(max_dev);
						1: d = -int'(max_dev);
						2: d = int'(max_dev) + 1;
						default: d = -int'(max_dev) - 1;
					endcase
					if ($urandom_range(0, 1)) begin
						v = int'(anchor_x) + d;
						fx = v[15:0];
					end else begin
						v = int'(anchor_y) + d;
						fy = v[15:0];
					end
				end else if (roll >= 70) begin
					fx = 16'($urandom_range(0, 65535));
					fy = 16'($urandom_range(0, 65535));
				end
				send_frame(lead, fill, fx, fy);
			end
			long_hold = 1'b0;
		end

		settle();
		if (err_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#2_000_000;
		$display("tb: errors");
		$finish;
	end

endmodule

// ===== uwb_position_frame_filter.f =====
rtl/uwbf_pkg.sv
rtl/uwbf_parser.sv
rtl/uwbf_cell.sv
rtl/uwbf_window.sv
rtl/uwb_position_frame_filter.sv
test/tb.sv
